// ----- sv/puq_pkg.sv -----
package puq_pkg;

    localparam int TableEntries = 256;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = IdxW + 1;
    localparam int PageShift = 12;

    localparam logic [62:0] SumMax = {63{1'b1}};

    typedef enum logic [2:0] {
        OP_CLR_USAGE  = 3'd0,
        OP_ACCUM      = 3'd1,
        OP_SET_LIMIT  = 3'd2,
        OP_CHECK      = 3'd3,
        OP_CLR_LIMITS = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_OVER = 2'd2,
        ST_NONE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY_SCAN,
        S_KEY_UPD,
        S_CHK_USAGE,
        S_CHK_LIMIT,
        S_OUT
    } t_state;

endpackage

// ----- sv/puq_if.sv -----
interface puq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] user_id;
    logic [31:0] rss_pages;
    logic [62:0] limit_bytes;
    modport source (output valid, opcode, user_id, rss_pages, limit_bytes, input ready);
    modport sink (input valid, opcode, user_id, rss_pages, limit_bytes, output ready);
endinterface

interface puq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] over_user;
    logic [7:0]  limit_slot;
    logic [7:0]  usage_slot;
    modport source (output valid, status, over_user, limit_slot, usage_slot, input ready);
    modport sink (input valid, status, over_user, limit_slot, usage_slot, output ready);
endinterface

// ----- sv/per_user_usage_quota_table_unit.sv -----
// Channel | Dir | Payload
// in      | in  | opcode, user_id, rss_pages, limit_bytes
// out     | out | status, over_user, limit_slot, usage_slot
//
// Each word is handled alone. Clears and unused opcodes go straight to output.
// Accumulate and set limit scan the keyed table one entry a cycle through
// the single read port. Check walks the usage table and, for each usage
// entry, scans the limit table until an offender is found, one read port per table.
// Reset (synchronous, active low) clears both counts and the control state;
// the memories need no clearing because only entries below a count are read.
// The result is held in an output register until taken; a stalled output
// holds the block, and a new word is taken once the result has been taken.
module per_user_usage_quota_table_unit
    import puq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    puq_in_if.sink      i_in,
    puq_out_if.source   o_out
);
    t_state r_state, n_state;
    logic [CntW-1:0] r_ucnt, n_ucnt, r_lcnt, n_lcnt;
    logic [2:0]  r_op;
    logic [31:0] r_uid;
    logic [62:0] r_arg;
    logic [CntW-1:0] r_i, n_i;   // scan index (usage walk or key scan)
    logic [CntW-1:0] r_k, n_k;   // limit scan index during check
    logic        r_rdv, n_rdv;   // read data valid for r_pend (for r_i in the usage walk)
    logic [CntW-1:0] r_pend, n_pend;
    logic [31:0] r_cur_user, n_cur_user;
    logic [62:0] r_cur_tot, n_cur_tot;
    logic [1:0]  r_st, n_st;
    logic [31:0] r_ov, n_ov;
    logic [7:0]  r_ls, n_ls, r_us, n_us;

    logic [IdxW-1:0] u_rd, l_rd;
    logic [31:0] u_key, l_key;
    logic [62:0] u_val, l_val;
    logic u_we, u_kwe, l_we, l_kwe;
    logic [IdxW-1:0] u_wa, l_wa;
    logic [31:0] u_wk, l_wk;
    logic [62:0] u_wv, l_wv;

    logic        is_usage;
    logic [CntW-1:0] cnt;
    logic [31:0] sel_key;
    logic [62:0] sel_val, sum_val;
    logic [63:0] sum;

    puq_table u_usage (
        .i_clk(i_clk), .i_rd_addr(u_rd), .o_rd_key(u_key), .o_rd_val(u_val),
        .i_wr_en(u_we), .i_wr_key_en(u_kwe), .i_wr_addr(u_wa),
        .i_wr_key(u_wk), .i_wr_val(u_wv)
    );
    puq_table u_limit (
        .i_clk(i_clk), .i_rd_addr(l_rd), .o_rd_key(l_key), .o_rd_val(l_val),
        .i_wr_en(l_we), .i_wr_key_en(l_kwe), .i_wr_addr(l_wa),
        .i_wr_key(l_wk), .i_wr_val(l_wv)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.status     = r_st;
    assign o_out.over_user  = r_ov;
    assign o_out.limit_slot = r_ls;
    assign o_out.usage_slot = r_us;

    assign is_usage = (r_op == OP_ACCUM);
    assign cnt      = is_usage ? r_ucnt : r_lcnt;
    assign sel_key  = is_usage ? u_key : l_key;
    assign sel_val  = is_usage ? u_val : l_val;
    // Saturating add of page bytes onto the stored usage total.
    assign sum      = {1'b0, sel_val} + {20'd0, r_arg[31:0], 12'd0};
    assign sum_val  = sum[63] ? SumMax : sum[62:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ucnt  <= '0;
            r_lcnt  <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ucnt  <= n_ucnt;
            r_lcnt  <= n_lcnt;
            r_rdv   <= n_rdv;
        end
        if (i_in.valid && i_in.ready) begin
            r_op  <= i_in.opcode;
            r_uid <= i_in.user_id;
            r_arg <= (i_in.opcode == OP_ACCUM) ? {31'd0, i_in.rss_pages} : i_in.limit_bytes;
        end
        r_i <= n_i; r_k <= n_k; r_pend <= n_pend;
        r_cur_user <= n_cur_user; r_cur_tot <= n_cur_tot;
        r_st <= n_st; r_ov <= n_ov; r_ls <= n_ls; r_us <= n_us;
    end

    always_comb begin
        n_state = r_state; n_ucnt = r_ucnt; n_lcnt = r_lcnt;
        n_i = r_i; n_k = r_k; n_rdv = 1'b0; n_pend = r_pend;
        n_cur_user = r_cur_user; n_cur_tot = r_cur_tot;
        n_st = r_st; n_ov = r_ov; n_ls = r_ls; n_us = r_us;
        u_rd = r_i[IdxW-1:0]; l_rd = r_i[IdxW-1:0];
        u_we = 1'b0; u_kwe = 1'b0; u_wa = r_pend[IdxW-1:0]; u_wk = r_uid; u_wv = r_arg;
        l_we = 1'b0; l_kwe = 1'b0; l_wa = r_pend[IdxW-1:0]; l_wk = r_uid; l_wv = r_arg;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_st = ST_DONE; n_ov = '0; n_ls = '0; n_us = '0;
                    n_i = '0; n_k = '0;
                    unique case (i_in.opcode)
                        OP_CLR_USAGE: begin
                            n_ucnt = '0; n_state = S_OUT;
                        end
                        OP_CLR_LIMITS: begin
                            n_lcnt = '0; n_state = S_OUT;
                        end
                        OP_ACCUM, OP_SET_LIMIT: n_state = S_KEY_SCAN;
                        OP_CHECK: begin
                            n_st = ST_NONE; n_state = S_CHK_USAGE;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_KEY_SCAN: begin
                // Issue read at r_i; compare data read for r_pend.
                if (r_rdv && sel_key == r_uid) begin
                    // Read the matched entry again so its total is at hand for the update.
                    u_rd = r_pend[IdxW-1:0];
                    n_state = S_KEY_UPD;
                end else if (r_i < cnt) begin
                    n_rdv = 1'b1; n_pend = r_i; n_i = r_i + 1'b1;
                end else if (!r_rdv || r_pend + 1'b1 == cnt || cnt == '0) begin
                    // Not found: append or report full.
                    if (cnt == CntW'(TableEntries)) begin
                        n_st = ST_FULL;
                    end else if (is_usage) begin
                        u_we = 1'b1; u_kwe = 1'b1; u_wa = cnt[IdxW-1:0];
                        u_wv = {r_arg[50:0], 12'd0};
                        n_ucnt = r_ucnt + 1'b1;
                    end else begin
                        l_we = 1'b1; l_kwe = 1'b1; l_wa = cnt[IdxW-1:0];
                        n_lcnt = r_lcnt + 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_KEY_UPD: begin
                if (is_usage) begin
                    u_we = 1'b1; u_wv = sum_val;
                end else begin
                    l_we = 1'b1;
                end
                n_state = S_OUT;
            end
            S_CHK_USAGE: begin
                // r_i is the usage entry; fetch it, then scan limits.
                if (r_rdv) begin
                    n_cur_user = u_key; n_cur_tot = u_val;
                    n_k = '0; n_state = S_CHK_LIMIT;
                end else if (r_i < r_ucnt) begin
                    n_rdv = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CHK_LIMIT: begin
                l_rd = r_k[IdxW-1:0];
                if (r_rdv && l_key == r_cur_user) begin
                    if (r_cur_tot > l_val) begin
                        n_st = ST_OVER; n_ov = r_cur_user;
                        n_ls = 8'(r_pend); n_us = 8'(r_i);
                        n_state = S_OUT;
                    end else begin
                        n_i = r_i + 1'b1; n_state = S_CHK_USAGE;
                    end
                end else if (r_k < r_lcnt) begin
                    n_rdv = 1'b1; n_pend = r_k; n_k = r_k + 1'b1;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_CHK_USAGE;
                end
            end
            S_OUT: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- sv/puq_table.sv -----
// One keyed table: user key memory and 63-bit value memory, registered read.
module puq_table
    import puq_pkg::*;
(
    input  logic              i_clk,
    input  logic [IdxW-1:0]   i_rd_addr,
    output logic [31:0]       o_rd_key,
    output logic [62:0]       o_rd_val,
    input  logic              i_wr_en,
    input  logic              i_wr_key_en,
    input  logic [IdxW-1:0]   i_wr_addr,
    input  logic [31:0]       i_wr_key,
    input  logic [62:0]       i_wr_val
);
    logic [31:0] r_key [TableEntries];
    logic [62:0] r_val [TableEntries];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_val[i_wr_addr] <= i_wr_val;
            if (i_wr_key_en) begin
                r_key[i_wr_addr] <= i_wr_key;
            end
        end
        o_rd_key <= r_key[i_rd_addr];
        o_rd_val <= r_val[i_rd_addr];
    end
endmodule

// ----- tb/tb_per_user_usage_quota_table_unit.sv -----
`timescale 1ns / 100ps

// The testbench runs a usage and limit table model beside the block and
// checks every result word in order against that model's prediction.
module tb_per_user_usage_quota_table_unit;
    import puq_pkg::*;

    // One input word as the driver holds it.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] user_id;
        logic [31:0] rss_pages;
        logic [62:0] limit_bytes;
    } t_req;

    // One result word, as predicted and as observed.
    typedef struct packed {
        t_status     status;
        logic [31:0] over_user;
        logic [7:0]  limit_slot;
        logic [7:0]  usage_slot;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    puq_in_if  req_bus ();
    puq_out_if rsp_bus ();

    per_user_usage_quota_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus.sink),
        .o_out   (rsp_bus.source)
    );

    // Words waiting for the driver, and results waiting for the block.
    t_req pending_words[$];
    t_rsp expected_rsps[$];

    // The shadow copy of both keyed tables.
    logic [CntW-1:0] usage_cnt;
    logic [31:0]     usage_uid[TableEntries];
    logic [62:0]     usage_bytes[TableEntries];
    logic [CntW-1:0] limit_cnt;
    logic [31:0]     limit_uid[TableEntries];
    logic [62:0]     limit_bytes[TableEntries];

    int  snd_idle_pct;
    int  rcv_stall_pct;
    int  mismatch_cnt;
    bit  word_taken;
    bit  timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Position of a user among the first n keys, or n when the user is absent.
    function automatic int find_limit(input logic [31:0] who);
        int idx;
        for (idx = 0; idx < limit_cnt; idx++) begin
            if (limit_uid[idx] == who) return idx;
        end
        return int'(limit_cnt);
    endfunction

    function automatic int find_usage(input logic [31:0] who);
        int idx;
        for (idx = 0; idx < usage_cnt; idx++) begin
            if (usage_uid[idx] == who) return idx;
        end
        return int'(usage_cnt);
    endfunction

    // Applies one word to the shadow tables and returns the result it causes.
    function automatic t_rsp apply_quota_word(input t_req w);
        t_rsp        r;
        int          k;
        int          idx;
        logic [63:0] added;
        logic [63:0] sum;
        r = '{status: ST_DONE, over_user: '0, limit_slot: '0, usage_slot: '0};
        case (w.opcode)
            OP_CLR_USAGE: begin
                usage_cnt = '0;
            end
            OP_ACCUM: begin
                added = {20'd0, w.rss_pages, 12'd0};
                k = find_usage(w.user_id);
                if (k < usage_cnt) begin
                    // Both operands are below 2^63, so the 64-bit sum cannot wrap.
                    sum = {1'b0, usage_bytes[k]} + added;
                    usage_bytes[k] = sum[63] ? SumMax : sum[62:0];
                end else if (usage_cnt >= TableEntries) begin
                    r.status = ST_FULL;
                end else begin
                    usage_uid[usage_cnt]   = w.user_id;
                    usage_bytes[usage_cnt] = added[62:0];
                    usage_cnt++;
                end
            end
            OP_SET_LIMIT: begin
                k = find_limit(w.user_id);
                if (k < limit_cnt) begin
                    limit_bytes[k] = w.limit_bytes;
                end else if (limit_cnt >= TableEntries) begin
                    r.status = ST_FULL;
                end else begin
                    limit_uid[limit_cnt]   = w.user_id;
                    limit_bytes[limit_cnt] = w.limit_bytes;
                    limit_cnt++;
                end
            end
            OP_CHECK: begin
                r.status = ST_NONE;
                // The first usage entry, in insertion order, that is strictly over
                // its matching limit wins.
                for (idx = 0; idx < usage_cnt; idx++) begin
                    k = find_limit(usage_uid[idx]);
                    if (k < limit_cnt && usage_bytes[idx] > limit_bytes[k]) begin
                        r.status     = ST_OVER;
                        r.over_user  = usage_uid[idx];
                        r.limit_slot = k[7:0];
                        r.usage_slot = idx[7:0];
                        break;
                    end
                end
            end
            OP_CLR_LIMITS: begin
                limit_cnt = '0;
            end
            default: begin
                // Unused opcodes leave the tables alone and report done.
            end
        endcase
        return r;
    endfunction

    function automatic t_req make_word(input logic [2:0] op, input logic [31:0] uid,
                                       input logic [31:0] pages, input logic [62:0] lim);
        t_req w;
        w.opcode      = op;
        w.user_id     = uid;
        w.rss_pages   = pages;
        w.limit_bytes = lim;
        return w;
    endfunction

    // Random word: mostly a small pool of users so that lookups hit and some
    // users go over limit, with full-width fields mixed in.
    function automatic t_req random_word();
        int          pick;
        logic [2:0]  op;
        logic [31:0] uid;
        logic [31:0] pages;
        logic [62:0] lim;
        pick = $urandom_range(99);
        if (pick < 35) op = OP_ACCUM;
        else if (pick < 63) op = OP_SET_LIMIT;
        else if (pick < 83) op = OP_CHECK;
        else if (pick < 89) op = OP_CLR_USAGE;
        else if (pick < 95) op = OP_CLR_LIMITS;
        else op = 3'($urandom_range(5, 7));
        if ($urandom_range(99) < 80) uid = $urandom_range(11);
        else if ($urandom_range(1) == 0) uid = 32'hFFFF_FFFF - $urandom_range(3);
        else uid = $urandom;
        if ($urandom_range(99) < 75) pages = $urandom_range(100);
        else pages = $urandom;
        if ($urandom_range(99) < 70) lim = 63'($urandom_range(250)) << PageShift;
        else lim = 63'({$urandom, $urandom}) & SumMax;
        return make_word(op, uid, pages, lim);
    endfunction

    // Monitor: results are checked first, then an accepted word is predicted.
    always @(posedge i_clk) begin
        t_rsp seen;
        t_rsp want;
        word_taken <= i_rst_n && req_bus.valid && req_bus.ready;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                seen = '{status: t_status'(rsp_bus.status), over_user: rsp_bus.over_user,
                         limit_slot: rsp_bus.limit_slot, usage_slot: rsp_bus.usage_slot};
                if (expected_rsps.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result word with none expected: %p", $realtime, seen);
                end else begin
                    want = expected_rsps.pop_front();
                    if (seen.status !== want.status || seen.over_user !== want.over_user
                        || seen.limit_slot !== want.limit_slot
                        || seen.usage_slot !== want.usage_slot) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, seen);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                expected_rsps.push_back(apply_quota_word(t_req'{req_bus.opcode,
                    req_bus.user_id, req_bus.rss_pages, req_bus.limit_bytes}));
            end
        end
    end

    // Driver: a word stays on the bus until taken; new words and ready change
    // at the falling edge only.
    always @(negedge i_clk) begin
        t_req w;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
            if (!req_bus.valid || word_taken) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    w = pending_words.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.opcode      <= w.opcode;
                    req_bus.user_id     <= w.user_id;
                    req_bus.rss_pages   <= w.rss_pages;
                    req_bus.limit_bytes <= w.limit_bytes;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    task automatic drain_all();
        wait (pending_words.size() == 0 && !req_bus.valid && expected_rsps.size() == 0);
    endtask

    initial begin
        int idx;
        int phase;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = '0;
        req_bus.user_id     = '0;
        req_bus.rss_pages   = '0;
        req_bus.limit_bytes = '0;
        rsp_bus.ready       = 1'b0;
        usage_cnt     = '0;
        limit_cnt     = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        mismatch_cnt  = 0;
        word_taken    = 1'b0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty check, unused opcodes, field extremes, overwrite of a
        // limit, and both clears.
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        for (idx = 5; idx <= 7; idx++)
            pending_words.push_back(make_word(3'(idx), 32'hFFFF_FFFF, 32'hFFFF_FFFF, SumMax));
        pending_words.push_back(make_word(OP_ACCUM, 0, 0, 0));
        pending_words.push_back(make_word(OP_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SumMax));
        pending_words.push_back(make_word(OP_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_words.push_back(make_word(OP_SET_LIMIT, 32'hFFFF_FFFF, 0, 0));
        pending_words.push_back(make_word(OP_SET_LIMIT, 0, 32'hFFFF_FFFF, SumMax));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_SET_LIMIT, 32'hFFFF_FFFF, 0, SumMax));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_SET_LIMIT, 0, 0, 0));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_CLR_LIMITS, 0, 0, 0));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_CLR_USAGE, 0, 0, 0));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));

        // Fill both tables, overflow each with a new user, and check with the
        // only offender in the last slot of both, which is the longest walk.
        for (idx = 0; idx < TableEntries; idx++)
            pending_words.push_back(make_word(OP_ACCUM, 100 + idx, 1, 0));
        pending_words.push_back(make_word(OP_ACCUM, 99, 1, 0));
        pending_words.push_back(make_word(OP_ACCUM, 100, 1, 0));
        for (idx = 0; idx < TableEntries; idx++)
            pending_words.push_back(make_word(OP_SET_LIMIT, 100 + idx, 0,
                                              idx == TableEntries - 1 ? 63'd0 : SumMax));
        pending_words.push_back(make_word(OP_SET_LIMIT, 99, 0, 0));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_SET_LIMIT, 100, 0, 0));
        pending_words.push_back(make_word(OP_CHECK, 0, 0, 0));
        pending_words.push_back(make_word(OP_CLR_USAGE, 0, 0, 0));
        pending_words.push_back(make_word(OP_CLR_LIMITS, 0, 0, 0));
        drain_all();

        // Random words in four idling phases: none, sender idle, receiver
        // stalling, and both at once.
        for (phase = 0; phase < 4; phase++) begin
            snd_idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 14 : 0;
            rcv_stall_pct = (phase == 2) ? 78 : (phase == 3) ? 14 : 0;
            for (idx = 0; idx < 128; idx++)
                pending_words.push_back(random_word());
            drain_all();
        end

        repeat (300) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        timed_out = 1'b0;
        #30ms;
        timed_out = 1'b1;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
